[rtl/tpr_pkg.sv]
// ----------------------------------------------------------------------------
// tpr_pkg: shared constants and helpers for the tilt angle pipeline
// Angle format, arctangent table and output rounding.
// ----------------------------------------------------------------------------
`default_nettype none

package tpr_pkg;

	// angle accumulator: degrees with 16 fraction bits
	localparam int ANG_W = 26;
	// rounded angle: degrees with 7 fraction bits
	localparam int OUT_W = ANG_W - 9;

	localparam logic signed [ANG_W-1:0] DEG90  = 26'sd5898240;
	localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;

	localparam logic signed [OUT_W-1:0] PITCH_LIM = 17'sd11520;
	localparam logic signed [OUT_W-1:0] ROLL_LIM  = 17'sd23040;

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic logic signed [ANG_W-1:0] atan_q16(input int i);
		logic signed [ANG_W-1:0] r;
		case (i)
			0:       r = 26'sd2949120;
			1:       r = 26'sd1740967;
			2:       r = 26'sd919879;
			3:       r = 26'sd466945;
			4:       r = 26'sd234379;
			5:       r = 26'sd117304;
			6:       r = 26'sd58666;
			7:       r = 26'sd29335;
			8:       r = 26'sd14668;
			9:       r = 26'sd7334;
			10:      r = 26'sd3667;
			11:      r = 26'sd1833;
			12:      r = 26'sd917;
			13:      r = 26'sd458;
			14:      r = 26'sd229;
			15:      r = 26'sd115;
			16:      r = 26'sd57;
			17:      r = 26'sd29;
			18:      r = 26'sd14;
			19:      r = 26'sd7;
			20:      r = 26'sd4;
			21:      r = 26'sd2;
			22:      r = 26'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// round half up to 7 fraction bits, then clamp to +/- lim
	function automatic logic signed [OUT_W-1:0] round_clamp(
		input logic signed [ANG_W-1:0] acc,
		input logic signed [OUT_W-1:0] lim
	);
		logic signed [ANG_W-1:0] s;
		logic signed [OUT_W-1:0] r;
		s = acc + 26'sd256;
		r = s[ANG_W-1:9];
		if (r > lim) begin
			r = lim;
		end else if (r < -lim) begin
			r = -lim;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/tpr_isqrt.sv]
// ----------------------------------------------------------------------------
// tpr_isqrt: pipelined integer square root
// One root bit per register stage, restoring digit-by-digit method.
// ----------------------------------------------------------------------------
`default_nettype none

module tpr_isqrt #(
	parameter int RW = 23
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*RW-1:0] radicand,
	output logic            out_valid,
	output logic [RW-1:0]   root
);

	logic [2*RW-1:0] n_s    [RW+1];
	logic [RW+2:0]   rem_s  [RW+1];
	logic [RW-1:0]   root_s [RW+1];
	logic            v_s    [RW+1];

	assign n_s[0]    = radicand;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign v_s[0]    = in_valid;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RW+2:0] rsh;
		logic [RW+2:0] trial;

		assign rsh   = {rem_s[k][RW:0], n_s[k][2*(RW-1-k)+1 -: 2]};
		assign trial = {1'b0, root_s[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k+1] <= n_s[k];
				if (rsh >= trial) begin
					rem_s[k+1]  <= rsh - trial;
					root_s[k+1] <= {root_s[k][RW-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= rsh;
					root_s[k+1] <= {root_s[k][RW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[RW];
	assign root      = root_s[RW];

endmodule

`default_nettype wire

[rtl/tpr_cordic.sv]
// ----------------------------------------------------------------------------
// tpr_cordic: pipelined vectoring CORDIC, atan2 in degrees
// A pre-rotation stage into the right half plane, then one stage per step.
// ----------------------------------------------------------------------------
`default_nettype none

module tpr_cordic #(
	parameter int IW    = 25,
	parameter int STEPS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic signed [IW-1:0]             vec_x,
	input  logic signed [IW-1:0]             vec_y,
	output logic                             out_valid,
	output logic signed [tpr_pkg::ANG_W-1:0] angle
);

	localparam int W = IW + 3;

	logic signed [W-1:0]              x_s  [STEPS+1];
	logic signed [W-1:0]              y_s  [STEPS+1];
	logic signed [tpr_pkg::ANG_W-1:0] a_s  [STEPS+1];
	logic                             sp_s [STEPS+1];
	logic                             v_s  [STEPS+1];

	logic signed [W-1:0]              xw, yw, xp, yp;
	logic signed [tpr_pkg::ANG_W-1:0] ap;
	logic                             spec;

	assign xw = W'(vec_x);
	assign yw = W'(vec_y);

	// zero axes give exact angles; left half plane turned by +/-90
	always_comb begin
		spec = 1'b0;
		xp   = xw;
		yp   = yw;
		ap   = '0;
		if (yw == '0) begin
			spec = 1'b1;
			ap   = (xw < 0) ? tpr_pkg::DEG180 : '0;
		end else if (xw == '0) begin
			spec = 1'b1;
			ap   = (yw > 0) ? tpr_pkg::DEG90 : -tpr_pkg::DEG90;
		end else if (xw < 0) begin
			if (yw > 0) begin
				xp = yw;
				yp = -xw;
				ap = tpr_pkg::DEG90;
			end else begin
				xp = -yw;
				yp = xw;
				ap = -tpr_pkg::DEG90;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= xp;
			y_s[0]  <= yp;
			a_s[0]  <= ap;
			sp_s[0] <= spec;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [tpr_pkg::ANG_W-1:0] ATN = tpr_pkg::atan_q16(i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sp_s[i+1] <= sp_s[i];
				if (sp_s[i]) begin
					x_s[i+1] <= x_s[i];
					y_s[i+1] <= y_s[i];
					a_s[i+1] <= a_s[i];
				end else if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] + ATN;
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] - ATN;
				end
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign angle     = a_s[STEPS];

endmodule

`default_nettype wire

[rtl/tilt_pitch_roll_from_accel.sv]
// ----------------------------------------------------------------------------
// tilt_pitch_roll_from_accel: pitch and roll from one accelerometer sample
// roll = atan2(y, z), pitch = atan2(-x, sqrt(y^2 + z^2)), 1/128 degree.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                   payload
//  accel    in         accel_valid / accel_stall   accel_x, accel_y, accel_z
//  angle    out        angle_valid / angle_stall   pitch_angle, roll_angle
//
//  One item per cycle unless a stalled result holds the pipeline; the square
//  root gives one root bit per stage and the CORDIC one step per stage.
//  Reset clears all valid bits; the pipeline is empty afterwards.
//  A stalled result freezes the whole pipeline and raises accel_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_pitch_roll_from_accel #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ANGLE_STEPS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accel_valid,
	output logic                           accel_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
	output logic                           angle_valid,
	input  logic                           angle_stall,
	output logic signed [14:0]             pitch_angle,
	output logic signed [15:0]             roll_angle
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int RW = SW + 7;
	localparam int IW = SW + 9;

	logic en;
	assign en          = !angle_valid || !angle_stall;
	assign accel_stall = !en;

	logic                 v_s1, v_s2, v_s3;
	logic signed [SW-1:0] ax_s1, ay_s1, az_s1;
	logic signed [SW-1:0] ax_s2, ay_s2, az_s2;
	logic signed [SW-1:0] ax_s3, ay_s3, az_s3;
	logic [2*SW-2:0]      ysq_s2, zsq_s2;
	logic [2*RW-1:0]      n_s3;
	logic signed [2*SW-1:0] ysq_full, zsq_full;
	logic [2*SW-1:0]      sq_sum;

	assign ysq_full = ay_s1 * ay_s1;
	assign zsq_full = az_s1 * az_s1;
	assign sq_sum   = {1'b0, ysq_s2} + {1'b0, zsq_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= accel_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= accel_x;
			ay_s1  <= accel_y;
			az_s1  <= accel_z;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			az_s2  <= az_s1;
			ysq_s2 <= ysq_full[2*SW-2:0];
			zsq_s2 <= zsq_full[2*SW-2:0];
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			az_s3  <= az_s2;
			n_s3   <= {sq_sum, 14'b0};
		end
	end

	// radius of (y, z), 7 fraction bits
	logic          rt_valid;
	logic [RW-1:0] root;

	tpr_isqrt #(
		.RW(RW)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.radicand (n_s3),
		.out_valid(rt_valid),
		.root     (root)
	);

	// samples held level with the square root
	logic signed [SW-1:0] dx_q [RW+1];
	logic signed [SW-1:0] dy_q [RW+1];
	logic signed [SW-1:0] dz_q [RW+1];

	assign dx_q[0] = ax_s3;
	assign dy_q[0] = ay_s3;
	assign dz_q[0] = az_s3;

	for (genvar k = 0; k < RW; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				dx_q[k+1] <= dx_q[k];
				dy_q[k+1] <= dy_q[k];
				dz_q[k+1] <= dz_q[k];
			end
		end
	end

	logic signed [IW-1:0] ax_w, p_x, p_y, r_x, r_y;

	assign ax_w = IW'(dx_q[RW]);
	assign p_x  = signed'({2'b00, root});
	assign p_y  = -(ax_w <<< 7);
	assign r_x  = signed'({dz_q[RW][SW-1], dz_q[RW], 8'b0});
	assign r_y  = signed'({dy_q[RW][SW-1], dy_q[RW], 8'b0});

	logic                             p_valid, r_valid;
	logic signed [tpr_pkg::ANG_W-1:0] p_acc, r_acc;

	tpr_cordic #(
		.IW   (IW),
		.STEPS(ANGLE_STEPS)
	) u_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (rt_valid),
		.vec_x    (p_x),
		.vec_y    (p_y),
		.out_valid(p_valid),
		.angle    (p_acc)
	);

	tpr_cordic #(
		.IW   (IW),
		.STEPS(ANGLE_STEPS)
	) u_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (rt_valid),
		.vec_x    (r_x),
		.vec_y    (r_y),
		.out_valid(r_valid),
		.angle    (r_acc)
	);

	logic signed [tpr_pkg::OUT_W-1:0] p_out, r_out;

	assign p_out = tpr_pkg::round_clamp(p_acc, tpr_pkg::PITCH_LIM);
	assign r_out = tpr_pkg::round_clamp(r_acc, tpr_pkg::ROLL_LIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_valid <= 1'b0;
		end else if (en) begin
			angle_valid <= p_valid && r_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pitch_angle <= p_out[14:0];
			roll_angle  <= r_out[15:0];
		end
	end

endmodule

`default_nettype wire
